### rtl/mm_pkg.sv
`default_nettype none

package mm_pkg;

  // sizes
  localparam int MAX_DIM = 8;
  localparam int DIM_W   = 4;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int ELEM_W  = 16;
  localparam int MUL_W   = 2 * ELEM_W;
  localparam int PROD_W  = 36;
  localparam int CFG_W   = 2;

  // configuration register indexes
  localparam logic [CFG_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_W-1:0] REG_INNER  = 2'd1;
  localparam logic [CFG_W-1:0] REG_COLS_B = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } mm_state_t;

  // control carried alongside each product through the pipeline
  typedef struct packed {
    logic             first;
    logic             last_k;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } mm_tag_t;

  // zero reads as one, anything above the maximum as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/mm_ram.sv
`default_nettype none

module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/matrix_multiply_unit.sv
// Load: one element per cycle, A then B; start is taken whenever busy is low.
// The element that completes B raises busy; each C[m][n] then follows with one strobe,
// registered after its last inner product has passed the store read and the multiply.
// All products go through the single shared multiply-accumulate.
// Results cannot be stalled. Reset sets all dimensions to 1 and restarts with A;
// the element stores are not cleared.
`default_nettype none

module matrix_multiply_unit
  import mm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [ELEM_W-1:0] in_element,
  output logic                         out_valid,
  output logic signed [PROD_W-1:0]     out_product,
  output logic [IDX_W-1:0]             out_row,
  output logic [IDX_W-1:0]             out_col,
  output logic                         out_last,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_W-1:0]        cfg_index,
  input  wire logic [DIM_W-1:0]        cfg_data
);

  // configuration
  logic [DIM_W-1:0] rows_a_r, inner_r, cols_b_r;
  logic [DIM_W-1:0] nr, nk, nc;
  logic             cfg_hit;

  // load and sequencer state
  mm_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic              loading_b_r, loading_b_nxt;
  logic [IDX_W-1:0]  m_r, m_nxt, n_r, n_nxt, k_r, k_nxt;
  logic [ADDR_W-1:0] a_base_r, a_base_nxt, b_addr_r, b_addr_nxt;
  logic [ADDR_W-1:0] a_addr;
  logic              accept, issue, k_end, n_end, m_end, issue_last, b_done;
  logic [CNT_W-1:0]  load_inc, a_total, b_total;

  // pipeline
  logic              s1_v_r, s2_v_r;
  mm_tag_t           s1_tag_r, s2_tag_r, issue_tag;
  logic [ELEM_W-1:0] a_rdata, b_rdata;
  logic signed [MUL_W-1:0]  mul_r;
  logic signed [PROD_W-1:0] acc_r, acc_sum;
  logic              out_valid_r, out_last_r;
  logic signed [PROD_W-1:0] out_product_r;
  logic [IDX_W-1:0]  out_row_r, out_col_r;

  assign nr = clamp_dim(rows_a_r);
  assign nk = clamp_dim(inner_r);
  assign nc = clamp_dim(cols_b_r);

  assign cfg_hit = cfg_we &&
                   (cfg_index == REG_ROWS_A || cfg_index == REG_INNER ||
                    cfg_index == REG_COLS_B);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DIM_W'(1);
      inner_r  <= DIM_W'(1);
      cols_b_r <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_A: rows_a_r <= cfg_data;
        REG_INNER:  inner_r  <= cfg_data;
        REG_COLS_B: cols_b_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // load bookkeeping
  assign accept   = start && !busy;
  assign load_inc = load_cnt_r + CNT_W'(1);
  assign a_total  = CNT_W'(nr) * CNT_W'(nk);
  assign b_total  = CNT_W'(nk) * CNT_W'(nc);
  assign b_done   = loading_b_r && (load_inc >= b_total);

  always_comb begin
    load_cnt_nxt  = load_cnt_r;
    loading_b_nxt = loading_b_r;
    if (cfg_hit) begin
      load_cnt_nxt  = '0;
      loading_b_nxt = 1'b0;
    end else if (accept) begin
      if (!loading_b_r) begin
        if (load_inc >= a_total) begin
          load_cnt_nxt  = '0;
          loading_b_nxt = 1'b1;
        end else begin
          load_cnt_nxt = load_inc;
        end
      end else if (b_done) begin
        load_cnt_nxt  = '0;
        loading_b_nxt = 1'b0;
      end else begin
        load_cnt_nxt = load_inc;
      end
    end
  end

  // element stores
  mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (accept && !loading_b_r),
    .waddr (load_cnt_r[ADDR_W-1:0]),
    .wdata (in_element),
    .raddr (a_addr),
    .rdata (a_rdata)
  );

  mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (accept && loading_b_r),
    .waddr (load_cnt_r[ADDR_W-1:0]),
    .wdata (in_element),
    .raddr (b_addr_r),
    .rdata (b_rdata)
  );

  // index walk over m, n, k
  assign k_end      = (k_r == IDX_W'(nk - DIM_W'(1)));
  assign n_end      = (n_r == IDX_W'(nc - DIM_W'(1)));
  assign m_end      = (m_r == IDX_W'(nr - DIM_W'(1)));
  assign issue_last = k_end && n_end && m_end;
  assign a_addr     = a_base_r + ADDR_W'(k_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:  if (accept && b_done) state_nxt = ST_RUN;
      ST_RUN:   if (issue_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!s1_v_r && !s2_v_r) state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    case (state_r)
      ST_LOAD:  busy  = 1'b0;
      ST_RUN:   issue = 1'b1;
      ST_DRAIN: ;
      default:  busy  = 1'b1;
    endcase
  end

  always_comb begin
    m_nxt      = m_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    a_base_nxt = a_base_r;
    b_addr_nxt = b_addr_r;
    if (state_r == ST_LOAD) begin
      m_nxt      = '0;
      n_nxt      = '0;
      k_nxt      = '0;
      a_base_nxt = '0;
      b_addr_nxt = '0;
    end else if (issue) begin
      if (!k_end) begin
        k_nxt      = k_r + IDX_W'(1);
        b_addr_nxt = b_addr_r + ADDR_W'(nc);
      end else begin
        k_nxt = '0;
        if (!n_end) begin
          n_nxt      = n_r + IDX_W'(1);
          b_addr_nxt = ADDR_W'(n_r) + ADDR_W'(1);
        end else begin
          n_nxt      = '0;
          b_addr_nxt = '0;
          m_nxt      = m_r + IDX_W'(1);
          a_base_nxt = a_base_r + ADDR_W'(nk);
        end
      end
    end
  end

  assign issue_tag = '{first:  (k_r == '0),
                       last_k: k_end,
                       row:    m_r,
                       col:    n_r,
                       last:   n_end && m_end};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      load_cnt_r  <= '0;
      loading_b_r <= 1'b0;
      m_r         <= '0;
      n_r         <= '0;
      k_r         <= '0;
      a_base_r    <= '0;
      b_addr_r    <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      loading_b_r <= loading_b_nxt;
      m_r         <= m_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      a_base_r    <= a_base_nxt;
      b_addr_r    <= b_addr_nxt;
      s1_v_r      <= issue;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r && s2_tag_r.last_k;
    end
  end

  // shared multiply-accumulate
  assign acc_sum = (s2_tag_r.first ? PROD_W'(0) : acc_r) + PROD_W'(mul_r);

  always_ff @(posedge clk) begin
    s1_tag_r <= issue_tag;
    s2_tag_r <= s1_tag_r;
    mul_r    <= signed'(a_rdata) * signed'(b_rdata);
    if (s2_v_r) begin
      acc_r <= acc_sum;
    end
    if (s2_v_r && s2_tag_r.last_k) begin
      out_product_r <= acc_sum;
      out_row_r     <= s2_tag_r.row;
      out_col_r     <= s2_tag_r.col;
      out_last_r    <= s2_tag_r.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_product = out_product_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  // the final result of a matrix is never followed at once by another
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("result strobe right after final element");

  // busy only drops with the pipeline empty
  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (!s1_v_r && !s2_v_r))
    else $error("busy dropped with products in flight");

  // a strobe only follows the last inner step of an element
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(s2_v_r && s2_tag_r.last_k))
    else $error("result strobe without a completed sum");

  // inner index stays within the inner dimension while running
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (k_r <= IDX_W'(nk - DIM_W'(1))))
    else $error("inner index out of range");
`endif

endmodule

`default_nettype wire
